/* src/range_kth_smallest_index_core_macros.svh */
// Assertion macros shared by the checker of the rank query core.
// Depends on a clock named clk and a reset named rst in the using scope.
`ifndef RANGE_KTH_SMALLEST_INDEX_CORE_MACROS_SVH
`define RANGE_KTH_SMALLEST_INDEX_CORE_MACROS_SVH
// same-cycle implication
`define RKSI_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rksi check failed");
// next-cycle implication
`define RKSI_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rksi check failed");
`endif

/* src/rksi_pkg.sv */
// Package for the rank query core: defaults, request kinds, FSM states,
// controller command and status structs. No dependencies.
`timescale 1ns / 1ps
package rksi_pkg;
  localparam int DEF_MAX_ITEMS  = 1024;
  localparam int DEF_VALUE_BITS = 32;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_LSTART, S_LSWEEP, S_DECIDE, S_FSTART, S_FSWEEP, S_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic load_query;
    logic start_sweep;
    logic step;
    logic find_mode;
    logic decide;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic sweep_done;
    logic last_level;
    logic out_free;
  } status_t;
endpackage

/* src/rksi_ctrl.sv */
// Controller FSM of the rank query core: sequences checks, level sweeps
// and the final position sweep. Depends on rksi_pkg.
`timescale 1ns / 1ps
module rksi_ctrl import rksi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic [1:0] kind,
  output logic    in_stall,
  input  status_t sts,
  output cmd_t    cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (kind == KIND_QUERY) begin
            cmd.load_query = 1'b1;
            state_next     = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        state_next = sts.bad ? S_DONE : S_LSTART;
      end
      S_LSTART: begin
        cmd.start_sweep = 1'b1;
        state_next      = S_LSWEEP;
      end
      S_LSWEEP: begin
        cmd.step = 1'b1;
        if (sts.sweep_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = sts.last_level ? S_FSTART : S_LSTART;
      end
      S_FSTART: begin
        cmd.start_sweep = 1'b1;
        cmd.find_mode   = 1'b1;
        state_next      = S_FSWEEP;
      end
      S_FSWEEP: begin
        cmd.step      = 1'b1;
        cmd.find_mode = 1'b1;
        if (sts.sweep_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

/* src/rksi_dp.sv */
// Datapath of the rank query core: value memory, count, radix-select
// registers, range sweep and result register. Depends on rksi_pkg.
`timescale 1ns / 1ps
module rksi_dp import rksi_pkg::*; #(
  parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         kind,
  input  logic signed [31:0] value,
  input  logic [10:0]        range_start,
  input  logic [10:0]        range_end,
  input  logic [9:0]         rank,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [9:0]         position,
  output logic               found,
  input  cmd_t               cmd,
  output status_t            sts
);
  localparam int AW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW   = $clog2(MAX_ITEMS + 1);
  localparam int CMPW = (CW > 11) ? CW : 11;
  localparam int VB   = VALUE_BITS;

  logic [VB-1:0]   mem [MAX_ITEMS];
  logic [VB-1:0]   rdata;
  logic [VB-1:0]   key_in;
  logic [VB-1:0]   ext;
  logic [CW-1:0]   count;
  logic [CMPW-1:0] ql, qr, qk, a, cnt, cnt_ext, count_ext, pos_ext;
  logic [AW-1:0]   rd_addr, pos;
  logic            rd_v, hit;
  logic [VB-1:0]   pre, mask, bm;
  logic            match_lvl, match_eq, issue;

  generate
    if (VB <= 32) begin : g_narrow
      assign ext = value[VB-1:0];
    end else begin : g_wide
      assign ext = {{(VB-32){value[31]}}, value};
    end
  endgenerate
  assign key_in = ext ^ {1'b1, {(VB-1){1'b0}}};

  assign count_ext = CMPW'(count);
  assign cnt_ext   = cnt;
  assign issue     = cmd.step && (a < qr);
  assign match_lvl = (((rdata ^ pre) & mask) == '0) && ((rdata & bm) == '0);
  assign match_eq  = (rdata == pre);
  assign pos_ext   = CMPW'(pos);

  assign sts.bad        = (ql > qr) || (qr > count_ext) || (qk >= (qr - ql));
  assign sts.sweep_done = (a == qr) && !rd_v;
  assign sts.last_level = bm[0];
  assign sts.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.take && (kind == KIND_APPEND) && (count_ext < CMPW'(MAX_ITEMS))) begin
      mem[count[AW-1:0]] <= key_in;
    end
    rdata <= mem[a[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
      rd_v      <= 1'b0;
    end else begin
      if (cmd.take && (kind == KIND_CLEAR)) begin
        count <= '0;
      end else if (cmd.take && (kind == KIND_APPEND)
                   && (count_ext < CMPW'(MAX_ITEMS))) begin
        count <= count + 1'b1;
      end
      if (cmd.start_sweep) begin
        rd_v <= 1'b0;
      end else begin
        rd_v <= issue;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      ql   <= CMPW'(range_start);
      qr   <= CMPW'(range_end);
      qk   <= CMPW'(rank);
      pre  <= '0;
      mask <= '0;
      bm   <= {1'b1, {(VB-1){1'b0}}};
    end
    if (cmd.start_sweep) begin
      a   <= ql;
      cnt <= '0;
      hit <= 1'b0;
    end else begin
      if (issue) begin
        a <= a + 1'b1;
      end
      rd_addr <= a[AW-1:0];
      if (rd_v) begin
        if (cmd.find_mode) begin
          if (match_eq) begin
            if ((cnt_ext == qk) && !hit) begin
              hit <= 1'b1;
              pos <= rd_addr;
            end
            cnt <= cnt + 1'b1;
          end
        end else if (match_lvl) begin
          cnt <= cnt + 1'b1;
        end
      end
    end
    if (cmd.decide) begin
      if (qk >= cnt_ext) begin
        qk  <= qk - cnt_ext;
        pre <= pre | bm;
      end
      mask <= mask | bm;
      bm   <= bm >> 1;
    end
    if (cmd.out_load) begin
      found    <= !sts.bad && hit;
      position <= (!sts.bad && hit) ? pos_ext[9:0] : 10'd0;
    end
  end
endmodule

/* src/range_kth_smallest_index_core.sv */
// Rank query core: holds up to MAX_ITEMS signed values and returns the position of the
// k-th smallest value in a position range, ties ordered by position. A valid query makes
// one sweep of the range through the value memory per value bit, then a sweep that
// finds the position. A query with a bad range or rank goes from the check state
// straight to the result. A stalled result holds back the next query's result until
// it is taken. Clear and append requests are taken in the idle state and give no result.
// Top level; depends on rksi_pkg, rksi_ctrl and rksi_dp.
`timescale 1ns / 1ps
module range_kth_smallest_index_core import rksi_pkg::*; #(
  parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [31:0] value,
  input  logic [10:0]        range_start,
  input  logic [10:0]        range_end,
  input  logic [9:0]         rank,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         position,
  output logic               found
);
  cmd_t    cmd;
  status_t sts;

  rksi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .kind(kind),
    .in_stall(in_stall), .sts(sts), .cmd(cmd)
  );

  rksi_dp #(.MAX_ITEMS(MAX_ITEMS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk(clk), .rst(rst), .kind(kind), .value(value),
    .range_start(range_start), .range_end(range_end), .rank(rank),
    .out_stall(out_stall), .out_valid(out_valid), .position(position),
    .found(found), .cmd(cmd), .sts(sts)
  );
endmodule

/* src/rksi_checker.sv */
// Port-level checker for the rank query core, bound to the top level.
// Depends on rksi_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "range_kth_smallest_index_core_macros.svh"
module rksi_checker import rksi_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  kind,
  input logic        out_valid,
  input logic        out_stall,
  input logic [9:0]  position,
  input logic        found
);
  `RKSI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(position) && $stable(found))
  `RKSI_ASSERT_NOW(a_miss_zero, out_valid && !found, position == 10'd0)
  `RKSI_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && kind == KIND_QUERY, in_stall)
  `RKSI_ASSERT_NOW(a_reset_quiet, $past(rst), !out_valid)
endmodule

bind range_kth_smallest_index_core rksi_checker u_chk (.*);

/* tb/sv/tb_range_kth_smallest_index_core.sv */
// Testbench for range_kth_smallest_index_core: a directed table, a full-memory pass and
// random load/query phases; results are checked against a stable-sort rank predictor
// or, for typed table rows, against expected values. Depends on rksi_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_range_kth_smallest_index_core;
  import rksi_pkg::*;

  localparam int DEPTH = 1024;
  localparam int LIMIT = 20_000_000;

  typedef struct {
    kind_t             kd;
    logic signed [31:0] val;
    logic [10:0]       lo;
    logic [10:0]       hi;
    logic [9:0]        rk;
    bit                typed;
    logic [9:0]        exp_pos;
    logic              exp_found;
  } row_t;

  typedef struct {
    logic [9:0] pos;
    logic       fnd;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  kind_t              kind = KIND_NONE;
  logic signed [31:0] value = '0;
  logic [10:0]        range_start = '0;
  logic [10:0]        range_end = '0;
  logic [9:0]         rank = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [9:0]         position;
  logic               found;

  logic               in_acc = 1'b0;
  bit                 quiet = 0;
  int                 errors = 0;
  int                 cycles = 0;
  int                 stall_left = 0;

  logic signed [31:0] seq_vals [DEPTH];
  int unsigned        seq_len = 0;
  answer_t            ans_buf [8];
  int                 ans_wr = 0;
  int                 ans_rd = 0;
  row_t               dir_rows [32];
  int                 n_dir = 0;

  range_kth_smallest_index_core uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .value(value), .range_start(range_start), .range_end(range_end), .rank(rank),
    .out_valid(out_valid), .out_stall(out_stall), .position(position), .found(found)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    in_acc <= in_valid && !in_stall;
  end

  always @(negedge clk) begin
    if (quiet || rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    answer_t a;
    if (!rst && out_valid && !out_stall) begin
      if (ans_wr == ans_rd) begin
        $error("unexpected result: position %0d found %0d", position, found);
        errors++;
      end else begin
        a = ans_buf[ans_rd % 8];
        ans_rd++;
        if (position !== a.pos) begin
          $error("position: expected %0d actual %0d", a.pos, position);
          errors++;
        end
        if (found !== a.fnd) begin
          $error("found: expected %0d actual %0d", a.fnd, found);
          errors++;
        end
      end
    end
  end

  // stable order: equal values rank by position
  function automatic answer_t kth_smallest(int unsigned l, int unsigned r, int unsigned k);
    answer_t     a;
    int unsigned cnt;
    a.pos = '0;
    a.fnd = 1'b0;
    if (l > r || r > seq_len || k >= r - l) return a;
    for (int unsigned p = l; p < r; p++) begin
      cnt = 0;
      for (int unsigned q = l; q < r; q++)
        if (seq_vals[q] < seq_vals[p] || (seq_vals[q] == seq_vals[p] && q < p)) cnt++;
      if (cnt == k) begin
        a.pos = p[9:0];
        a.fnd = 1'b1;
        return a;
      end
    end
    return a;
  endfunction

  task automatic apply_request(row_t rq);
    answer_t a;
    int      gap;
    gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind        <= rq.kd;
    value       <= rq.val;
    range_start <= rq.lo;
    range_end   <= rq.hi;
    rank        <= rq.rk;
    in_valid    <= 1'b1;
    do @(negedge clk); while (!in_acc);
    case (rq.kd)
      KIND_CLEAR: seq_len = 0;
      KIND_APPEND: begin
        if (seq_len < DEPTH) begin
          seq_vals[seq_len] = rq.val;
          seq_len++;
        end
      end
      KIND_QUERY: begin
        if (rq.typed) begin
          a.pos = rq.exp_pos;
          a.fnd = rq.exp_found;
        end else begin
          a = kth_smallest(rq.lo, rq.hi, rq.rk);
        end
        ans_buf[ans_wr % 8] = a;
        ans_wr++;
      end
      default: ;
    endcase
  endtask

  function automatic void add_row(row_t rq);
    dir_rows[n_dir] = rq;
    n_dir++;
  endfunction

  function automatic row_t mk(kind_t kd, logic signed [31:0] val, int lo, int hi, int rk);
    row_t rq;
    rq.kd = kd;
    rq.val = val;
    rq.lo = 11'(lo);
    rq.hi = 11'(hi);
    rq.rk = 10'(rk);
    rq.typed = 0;
    rq.exp_pos = '0;
    rq.exp_found = 1'b0;
    return rq;
  endfunction

  function automatic row_t miss(int lo, int hi, int rk);
    row_t rq;
    rq = mk(KIND_QUERY, 0, lo, hi, rk);
    rq.typed = 1;
    return rq;
  endfunction

  function automatic logic signed [31:0] rand_value();
    if ($urandom_range(0, 1) == 0) return $signed($urandom_range(0, 6)) - 3;
    return $urandom;
  endfunction

  initial begin
    row_t        rq;
    int unsigned n_items;
    int unsigned len, lo, hi, wait_cnt;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_row(miss(0, 0, 0));
    add_row(miss(0, 1, 0));
    add_row(mk(KIND_NONE, 32'h7fffffff, 2047, 2047, 1023));
    add_row(mk(KIND_APPEND, 32'sh80000000, 0, 0, 0));
    add_row(mk(KIND_APPEND, 32'sh7fffffff, 0, 0, 0));
    add_row(mk(KIND_APPEND, 0, 0, 0, 0));
    add_row(mk(KIND_APPEND, -1, 0, 0, 0));
    add_row(mk(KIND_APPEND, 5, 0, 0, 0));
    add_row(mk(KIND_APPEND, 5, 0, 0, 0));
    add_row(mk(KIND_APPEND, -1, 0, 0, 0));
    rq = miss(0, 7, 0); rq.exp_found = 1'b1; add_row(rq);
    rq = miss(0, 7, 6); rq.exp_pos = 10'd1; rq.exp_found = 1'b1; add_row(rq);
    add_row(mk(KIND_QUERY, 0, 0, 7, 1));
    add_row(mk(KIND_QUERY, 0, 1, 7, 4));
    add_row(mk(KIND_QUERY, 0, 2, 6, 3));
    add_row(miss(5, 4, 0));
    add_row(miss(0, 8, 0));
    add_row(miss(2, 4, 2));
    add_row(miss(3, 3, 0));
    add_row(miss(2047, 2047, 1023));
    add_row(mk(KIND_CLEAR, 0, 0, 0, 0));
    add_row(miss(0, 1, 0));
    for (int i = 0; i < n_dir; i++) apply_request(dir_rows[i]);

    // fill past capacity so the last appends are dropped
    for (int i = 0; i < DEPTH + 6; i++) apply_request(mk(KIND_APPEND, rand_value(), 0, 0, 0));
    apply_request(mk(KIND_QUERY, 0, 0, 1024, 1023));
    apply_request(mk(KIND_QUERY, 0, 0, 1024, $urandom_range(0, 1023)));
    apply_request(mk(KIND_QUERY, 0, 1000, 1024, 23));
    apply_request(miss(1024, 1024, 0));
    apply_request(miss(0, 1025, 0));
    apply_request(mk(KIND_CLEAR, 0, 0, 0, 0));

    n_items = 0;
    while (n_items < 950) begin
      if (n_items > 800) quiet = 1;
      apply_request(mk(KIND_CLEAR, 0, 0, 0, 0));
      len = $urandom_range(0, 40);
      for (int i = 0; i < len; i++) apply_request(mk(KIND_APPEND, rand_value(), 0, 0, 0));
      n_items += len + 1;
      repeat ($urandom_range(1, 20)) begin
        case ($urandom_range(0, 19))
          0: rq = mk(KIND_QUERY, 0, $urandom_range(0, 2047), $urandom_range(0, 2047),
                     $urandom_range(0, 1023));
          1: rq = mk(KIND_NONE, $urandom, $urandom_range(0, 2047), $urandom_range(0, 2047),
                     $urandom_range(0, 1023));
          2: rq = mk(KIND_APPEND, rand_value(), 0, 0, 0);
          default: begin
            if (seq_len == 0) begin
              rq = mk(KIND_QUERY, 0, 0, 0, $urandom_range(0, 3));
            end else begin
              lo = $urandom_range(0, seq_len - 1);
              hi = $urandom_range(lo + 1, (lo + 16 < seq_len) ? lo + 16 : seq_len);
              rq = mk(KIND_QUERY, 0, lo, hi,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20)
                                                   : $urandom_range(0, hi - lo - 1));
            end
          end
        endcase
        apply_request(rq);
        n_items++;
      end
    end

    in_valid <= 1'b0;
    wait_cnt = 0;
    while (ans_wr != ans_rd && wait_cnt < 200000) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (200) @(negedge clk);
    if (ans_wr != ans_rd) begin
      $error("results missing: %0d", ans_wr - ans_rd);
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+src
src/rksi_pkg.sv
src/rksi_ctrl.sv
src/rksi_dp.sv
src/range_kth_smallest_index_core.sv
src/rksi_checker.sv
tb/sv/tb_range_kth_smallest_index_core.sv
